### rtl/core/chacha_pkg.sv
// Shared types, constants and round helpers of the ChaCha20 stream XOR block.
package chacha_pkg;

  // Default number of rounds
  localparam int RoundCountDef = 20;

  // Configuration port geometry: five 64-bit registers at 8-byte spacing
  localparam int CfgDataW = 64;
  localparam int CfgAddrW = 6;

  // Register indexes (byte address / 8)
  localparam logic [2:0] RegKey0  = 3'd0;
  localparam logic [2:0] RegKey1  = 3'd1;
  localparam logic [2:0] RegKey2  = 3'd2;
  localparam logic [2:0] RegKey3  = 3'd3;
  localparam logic [2:0] RegNonce = 3'd4;

  // Fixed constant words of the initial state
  localparam logic [31:0] Sigma0 = 32'h6170_7865;
  localparam logic [31:0] Sigma1 = 32'h3320_646E;
  localparam logic [31:0] Sigma2 = 32'h7962_2D32;
  localparam logic [31:0] Sigma3 = 32'h6B20_6574;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load_item;  // latch the accepted transaction
    logic load_init;  // load working state from key, counter and nonce
    logic do_step;    // run one half quarter-round on all four lanes
    logic half;       // 0: rotates 16/12, 1: rotates 8/7
    logic diag;       // 0: column round, 1: diagonal round
    logic finalize;   // add initial state into working state
    logic emit;       // load output register and advance position
  } cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic pos_zero;   // incoming transaction starts a keystream block
    logic out_free;   // output register can take a result this cycle
  } sts_t;

  // Four words of one quarter-round lane
  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
    logic [31:0] d;
  } qr_t;

  function automatic logic [31:0] rotl32(input logic [31:0] x, input int s);
    rotl32 = (x << s) | (x >> (32 - s));
  endfunction

  // Half of a quarter-round: two dependent adds
  function automatic qr_t qr_half(input qr_t v, input logic second);
    qr_t r;
    r = v;
    r.a = r.a + r.b;
    r.d = second ? rotl32(r.d ^ r.a, 8) : rotl32(r.d ^ r.a, 16);
    r.c = r.c + r.d;
    r.b = second ? rotl32(r.b ^ r.c, 7) : rotl32(r.b ^ r.c, 12);
    qr_half = r;
  endfunction

  // State word index of a lane's row for column or diagonal rounds
  function automatic logic [3:0] lane_idx(input int lane, input int row, input logic diag);
    logic [1:0] col;
    col = diag ? 2'(lane + row) : 2'(lane);
    lane_idx = {2'(row), col};
  endfunction

endpackage

### rtl/core/chacha_if.sv
// Stream interfaces for message input and cipher output transactions.
interface chacha_in_if;
  logic        valid;
  logic        ready;
  logic [63:0] data_in;
  logic [3:0]  byte_count;
  logic        first_item;

  modport source (output valid, output data_in, output byte_count, output first_item,
                  input ready);
  modport sink (input valid, input data_in, input byte_count, input first_item,
                output ready);
endinterface

interface chacha_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] data_out;
  logic [3:0]  valid_bytes;
  logic        counter_wrapped;

  modport source (output valid, output data_out, output valid_bytes,
                  output counter_wrapped, input ready);
  modport sink (input valid, input data_out, input valid_bytes,
                input counter_wrapped, output ready);
endinterface

### rtl/core/chacha_ctrl.sv
// Controller state machine: sequences accept, rounds, finalize and emit.
module chacha_ctrl #(
  parameter int ROUND_COUNT = chacha_pkg::RoundCountDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  chacha_pkg::sts_t   sts_i,
  output chacha_pkg::cmd_t   cmd_o
);

  localparam int StepCount = 2 * ROUND_COUNT;
  localparam int StepW     = $clog2(StepCount);
  localparam logic [StepW-1:0] LastStep = StepW'(StepCount - 1);

  localparam logic [1:0] StIdle  = 2'd0;
  localparam logic [1:0] StRound = 2'd1;
  localparam logic [1:0] StFinal = 2'd2;
  localparam logic [1:0] StEmit  = 2'd3;

  logic [1:0]       state_q, state_d;
  logic [StepW-1:0] step_q, step_d;

  // Next state and command decode
  always_comb begin
    state_d    = state_q;
    step_d     = step_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_item = 1'b1;
          if (sts_i.pos_zero) begin
            cmd_o.load_init = 1'b1;
            step_d          = '0;
            state_d         = StRound;
          end else begin
            state_d = StEmit;
          end
        end
      end
      StRound: begin
        cmd_o.do_step = 1'b1;
        cmd_o.half    = step_q[0];
        cmd_o.diag    = step_q[1];
        if (step_q == LastStep) begin
          state_d = StFinal;
        end else begin
          step_d = step_q + StepW'(1);
        end
      end
      StFinal: begin
        cmd_o.finalize = 1'b1;
        state_d        = StEmit;
      end
      StEmit: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

endmodule

### rtl/core/chacha_dp.sv
// Datapath: working state with four lane quarter-round units, counters, output register.
module chacha_dp (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  chacha_pkg::cmd_t       cmd_i,
  output chacha_pkg::sts_t       sts_o,
  input  logic [3:0][63:0]       key_i,
  input  logic [63:0]            nonce_i,
  input  logic [63:0]            data_in_i,
  input  logic [3:0]             byte_count_i,
  input  logic                   first_item_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [63:0]            data_out_o,
  output logic [3:0]             valid_bytes_o,
  output logic                   counter_wrapped_o
);

  // Working state; after finalize it holds the keystream block
  logic [31:0] w_q [16];
  logic [31:0] w_d [16];
  logic [31:0] init_w [16];

  logic [63:0] counter_q;
  logic [2:0]  pos_q;
  logic        wrap_q;
  logic [63:0] data_q;
  logic [3:0]  count_q;
  logic        out_valid_q;
  logic [63:0] ctr_sel;
  logic [63:0] ks;
  logic [63:0] mask;
  logic        wrap_now;

  // Status back to the controller
  assign sts_o.pos_zero = first_item_i | (pos_q == 3'd0);
  assign sts_o.out_free = ~out_valid_q | out_ready_i;

  // Counter seen by the initial state; a first transaction restarts it
  assign ctr_sel = (cmd_i.load_item && first_item_i) ? 64'd0 : counter_q;

  // Initial state words
  always_comb begin
    init_w[0]  = chacha_pkg::Sigma0;
    init_w[1]  = chacha_pkg::Sigma1;
    init_w[2]  = chacha_pkg::Sigma2;
    init_w[3]  = chacha_pkg::Sigma3;
    for (int i = 0; i < 4; i++) begin
      init_w[4 + 2*i] = key_i[i][31:0];
      init_w[5 + 2*i] = key_i[i][63:32];
    end
    init_w[12] = ctr_sel[31:0];
    init_w[13] = ctr_sel[63:32];
    init_w[14] = nonce_i[31:0];
    init_w[15] = nonce_i[63:32];
  end

  // Working state update
  always_comb begin
    chacha_pkg::qr_t lv;
    chacha_pkg::qr_t lr;
    for (int i = 0; i < 16; i++) begin
      w_d[i] = w_q[i];
    end
    lv = '0;
    lr = '0;
    if (cmd_i.load_init) begin
      for (int i = 0; i < 16; i++) begin
        w_d[i] = init_w[i];
      end
    end else if (cmd_i.do_step) begin
      for (int l = 0; l < 4; l++) begin
        lv.a = w_q[chacha_pkg::lane_idx(l, 0, cmd_i.diag)];
        lv.b = w_q[chacha_pkg::lane_idx(l, 1, cmd_i.diag)];
        lv.c = w_q[chacha_pkg::lane_idx(l, 2, cmd_i.diag)];
        lv.d = w_q[chacha_pkg::lane_idx(l, 3, cmd_i.diag)];
        lr   = chacha_pkg::qr_half(lv, cmd_i.half);
        w_d[chacha_pkg::lane_idx(l, 0, cmd_i.diag)] = lr.a;
        w_d[chacha_pkg::lane_idx(l, 1, cmd_i.diag)] = lr.b;
        w_d[chacha_pkg::lane_idx(l, 2, cmd_i.diag)] = lr.c;
        w_d[chacha_pkg::lane_idx(l, 3, cmd_i.diag)] = lr.d;
      end
    end else if (cmd_i.finalize) begin
      for (int i = 0; i < 16; i++) begin
        w_d[i] = w_q[i] + init_w[i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 16; i++) begin
      w_q[i] <= w_d[i];
    end
  end

  // Keystream pair for the current position, byte mask, wrap after update
  assign ks = {w_q[{pos_q, 1'b1}], w_q[{pos_q, 1'b0}]};

  always_comb begin
    for (int b = 0; b < 8; b++) begin
      mask[8*b +: 8] = (count_q > 4'(b)) ? 8'hFF : 8'h00;
    end
  end

  assign wrap_now = wrap_q | ((pos_q == 3'd7) && (counter_q == '1));

  // Transaction payload latch
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      data_q  <= data_in_i;
      count_q <= byte_count_i;
    end
  end

  // Position, block counter and sticky wrap flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      counter_q <= '0;
      pos_q     <= '0;
      wrap_q    <= 1'b0;
    end else if (cmd_i.load_item && first_item_i) begin
      counter_q <= '0;
      pos_q     <= '0;
      wrap_q    <= 1'b0;
    end else if (cmd_i.emit) begin
      pos_q  <= pos_q + 3'd1;
      wrap_q <= wrap_now;
      if (pos_q == 3'd7) begin
        counter_q <= counter_q + 64'd1;
      end
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      data_out_o        <= (data_q ^ ks) & mask;
      valid_bytes_o     <= count_q;
      counter_wrapped_o <= wrap_now;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

### rtl/core/chacha20_stream_xor.sv
// ChaCha20 stream XOR (64-bit counter, 64-bit nonce): configuration registers and core.
// A transaction that opens a keystream block (position zero or first flag) runs
// through the round and finalize states before emit: one half quarter-round per cycle
// on four lanes, then one finalize add. Other transactions go from accept straight
// to emit. One transaction is in work at a time; a result may wait in the output
// register while the next is accepted. Reset clears keys, nonce, counter, position
// and wrap flag at once; no clearing pass.
module chacha20_stream_xor #(
  parameter int ROUND_COUNT = chacha_pkg::RoundCountDef
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  chacha_in_if.sink                      in_i,
  chacha_out_if.source                   out_o,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [chacha_pkg::CfgAddrW-1:0] paddr,
  input  logic [chacha_pkg::CfgDataW-1:0] pwdata,
  output logic [chacha_pkg::CfgDataW-1:0] prdata,
  output logic                           pready
);

  logic [3:0][63:0]  key_q;
  logic [63:0]       nonce_q;
  logic [2:0]        reg_idx;
  logic              cfg_wr;
  chacha_pkg::cmd_t  cmd;
  chacha_pkg::sts_t  sts;

  assign pready  = 1'b1;
  assign reg_idx = paddr[5:3];
  assign cfg_wr  = psel & penable & pwrite;

  // Register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q   <= '0;
      nonce_q <= '0;
    end else if (cfg_wr) begin
      case (reg_idx)
        chacha_pkg::RegKey0:  key_q[0] <= pwdata;
        chacha_pkg::RegKey1:  key_q[1] <= pwdata;
        chacha_pkg::RegKey2:  key_q[2] <= pwdata;
        chacha_pkg::RegKey3:  key_q[3] <= pwdata;
        chacha_pkg::RegNonce: nonce_q  <= pwdata;
        default: ;
      endcase
    end
  end

  // Register readback
  always_comb begin
    case (reg_idx)
      chacha_pkg::RegKey0:  prdata = key_q[0];
      chacha_pkg::RegKey1:  prdata = key_q[1];
      chacha_pkg::RegKey2:  prdata = key_q[2];
      chacha_pkg::RegKey3:  prdata = key_q[3];
      chacha_pkg::RegNonce: prdata = nonce_q;
      default:              prdata = '0;
    endcase
  end

  chacha_ctrl #(
    .ROUND_COUNT(ROUND_COUNT)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  chacha_dp u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .key_i             (key_q),
    .nonce_i           (nonce_q),
    .data_in_i         (in_i.data_in),
    .byte_count_i      (in_i.byte_count),
    .first_item_i      (in_i.first_item),
    .out_valid_o       (out_o.valid),
    .out_ready_i       (out_o.ready),
    .data_out_o        (out_o.data_out),
    .valid_bytes_o     (out_o.valid_bytes),
    .counter_wrapped_o (out_o.counter_wrapped)
  );

endmodule

### dv/tb_chacha20_stream_xor.sv
// Self-checking testbench of the ChaCha20 stream XOR block: random traffic against a keystream mirror.
module tb_chacha20_stream_xor;

  localparam int NUM_ROUNDS   = 20;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int SETTLE_TICKS = 60;

  // ChaCha "expand 32-byte k" constant words
  localparam logic [31:0] EXPA = 32'h6170_7865;
  localparam logic [31:0] ND_3 = 32'h3320_646E;
  localparam logic [31:0] TWO_B = 32'h7962_2D32;
  localparam logic [31:0] YTE_K = 32'h6B20_6574;

  // One output transaction as the block should produce it
  typedef struct packed {
    logic [63:0] data;
    logic [3:0]  nbytes;
    logic        wrap;
  } cipher_word_t;

  // Mirror of the cipher state; holds the ciphertext still awaited from the block
  class xor_stream_calc;
    logic [63:0]  key_reg [4];
    logic [63:0]  nonce_reg;
    logic [31:0]  stream_words [16];
    logic [31:0]  work [16];
    logic [63:0]  blk_count;
    logic [2:0]   slot;
    logic         wrapped;
    cipher_word_t awaited [$];
    int unsigned  mismatches;
    int unsigned  compared;

    function new();
      foreach (key_reg[k]) key_reg[k] = '0;
      nonce_reg  = '0;
      blk_count  = '0;
      slot       = '0;
      wrapped    = 1'b0;
      mismatches = 0;
      compared   = 0;
    endfunction

    function void set_reg(logic [2:0] idx, logic [63:0] value);
      case (idx)
        chacha_pkg::RegKey0:  key_reg[0] = value;
        chacha_pkg::RegKey1:  key_reg[1] = value;
        chacha_pkg::RegKey2:  key_reg[2] = value;
        chacha_pkg::RegKey3:  key_reg[3] = value;
        chacha_pkg::RegNonce: nonce_reg = value;
        default: ;
      endcase
    endfunction

    function logic [31:0] spin(logic [31:0] v, int unsigned n);
      return (v << n) | (v >> (32 - n));
    endfunction

    function void quarter_mix(int a, int b, int c, int d);
      work[a] = work[a] + work[b]; work[d] = spin(work[d] ^ work[a], 16);
      work[c] = work[c] + work[d]; work[b] = spin(work[b] ^ work[c], 12);
      work[a] = work[a] + work[b]; work[d] = spin(work[d] ^ work[a], 8);
      work[c] = work[c] + work[d]; work[b] = spin(work[b] ^ work[c], 7);
    endfunction

    // New 64-byte keystream block from key, counter and nonce
    function void refill();
      logic [31:0] seed [16];
      seed[0] = EXPA;
      seed[1] = ND_3;
      seed[2] = TWO_B;
      seed[3] = YTE_K;
      for (int k = 0; k < 4; k++) begin
        seed[4 + 2 * k] = key_reg[k][31:0];
        seed[5 + 2 * k] = key_reg[k][63:32];
      end
      seed[12] = blk_count[31:0];
      seed[13] = blk_count[63:32];
      seed[14] = nonce_reg[31:0];
      seed[15] = nonce_reg[63:32];
      work = seed;
      // column rounds on even passes, diagonal rounds on odd ones
      for (int r = 0; r < NUM_ROUNDS; r++) begin
        if (r % 2 == 0) begin
          quarter_mix(0, 4, 8, 12);
          quarter_mix(1, 5, 9, 13);
          quarter_mix(2, 6, 10, 14);
          quarter_mix(3, 7, 11, 15);
        end else begin
          quarter_mix(0, 5, 10, 15);
          quarter_mix(1, 6, 11, 12);
          quarter_mix(2, 7, 8, 13);
          quarter_mix(3, 4, 9, 14);
        end
      end
      for (int i = 0; i < 16; i++) stream_words[i] = work[i] + seed[i];
    endfunction

    // Accepted input transaction: work out the ciphertext it must give
    function void take_plaintext(logic [63:0] data, logic [3:0] nbytes, logic first);
      logic [63:0]  keystream;
      logic [63:0]  keep;
      cipher_word_t due;
      int           idx;
      if (first) begin
        blk_count = '0;
        slot      = '0;
        wrapped   = 1'b0;
      end
      if (slot == 3'd0) refill();
      idx       = 2 * int'(slot);
      keystream = {stream_words[idx + 1], stream_words[idx]};
      // counts above eight keep all bytes; zero keeps none
      keep = (nbytes >= 4'd8) ? {64{1'b1}} : ((64'd1 << {nbytes, 3'b000}) - 64'd1);
      slot = slot + 3'd1;
      if (slot == 3'd0) begin
        blk_count = blk_count + 64'd1;
        if (blk_count == 64'd0) wrapped = 1'b1;
      end
      due.data   = (data ^ keystream) & keep;
      due.nbytes = nbytes;
      due.wrap   = wrapped;
      awaited.push_back(due);
    endfunction

    task report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      $display("MISMATCH %s: got %h, want %h (after %0d results)", what, got, want, compared);
      mismatches++;
    endtask

    // Accepted output transaction: compare with the oldest awaited one
    task match_ciphertext(logic [63:0] data, logic [3:0] nbytes, logic wrap);
      cipher_word_t want;
      if (awaited.size() == 0) begin
        report_mismatch("result with nothing awaited, data_out", data, '0);
        return;
      end
      want = awaited.pop_front();
      compared++;
      if (data !== want.data) report_mismatch("data_out", data, want.data);
      if (nbytes !== want.nbytes)
        report_mismatch("valid_bytes", 64'(nbytes), 64'(want.nbytes));
      if (wrap !== want.wrap)
        report_mismatch("counter_wrapped", 64'(wrap), 64'(want.wrap));
    endtask
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [chacha_pkg::CfgAddrW-1:0] paddr;
  logic [chacha_pkg::CfgDataW-1:0] pwdata;
  logic [chacha_pkg::CfgDataW-1:0] prdata;
  logic        pready;

  chacha_in_if  in_bus ();
  chacha_out_if out_bus ();

  xor_stream_calc calc = new();

  int unsigned tx_idle_pct = 0;
  int unsigned rx_idle_pct = 0;
  int unsigned rx_hold = 0;
  int unsigned items_sent = 0;
  int unsigned settings_used = 0;
  int unsigned cycles = 0;

  chacha20_stream_xor #(
    .ROUND_COUNT(NUM_ROUNDS)
  ) i_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_bus),
    .out_o   (out_bus),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #10 clk_i = ~clk_i;

  // Watchdog
  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("tb_chacha20_stream_xor failed");
    $finish;
  end

  // Output side: check accepted transactions, then pick ready for the next edge
  initial begin
    out_bus.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (out_bus.valid && out_bus.ready)
        calc.match_ciphertext(out_bus.data_out, out_bus.valid_bytes, out_bus.counter_wrapped);
      if (rx_hold > 0) begin
        rx_hold--;
        out_bus.ready <= 1'b0;
      end else begin
        out_bus.ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  function automatic logic [63:0] rand64();
    case ($urandom_range(15))
      0: return '0;
      1: return {64{1'b1}};
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // APB write: setup cycle, access cycle, then an idle bus before the task returns
  task automatic cfg_write(input logic [2:0] idx, input logic [63:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    calc.set_reg(idx, value);
    @(posedge clk_i);
  endtask

  // Offer one input transaction, with random idle cycles ahead of it
  task automatic push_item(input logic [63:0] data, input logic [3:0] nbytes,
                           input logic first);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_bus.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_bus.valid      <= 1'b1;
    in_bus.data_in    <= data;
    in_bus.byte_count <= nbytes;
    in_bus.first_item <= first;
    do @(posedge clk_i); while (!in_bus.ready);
    calc.take_plaintext(data, nbytes, first);
    items_sent++;
  endtask

  // Stop offering and wait until every awaited result is back
  task automatic wait_for_outputs();
    in_bus.valid <= 1'b0;
    while (calc.awaited.size() != 0) @(posedge clk_i);
  endtask

  task automatic load_keys(input logic [63:0] k0, input logic [63:0] k1,
                           input logic [63:0] k2, input logic [63:0] k3,
                           input logic [63:0] nonce);
    wait_for_outputs();
    cfg_write(chacha_pkg::RegKey0, k0);
    cfg_write(chacha_pkg::RegKey1, k1);
    cfg_write(chacha_pkg::RegKey2, k2);
    cfg_write(chacha_pkg::RegKey3, k3);
    cfg_write(chacha_pkg::RegNonce, nonce);
    settings_used++;
  endtask

  // Well-formed message: full items, a short-or-full last one
  task automatic send_message(input int len);
    for (int i = 0; i < len; i++)
      push_item(rand64(), (i == len - 1) ? 4'($urandom_range(8, 1)) : 4'd8, i == 0);
  endtask

  // Mostly messages of random length, some loose transactions with any count or flag
  task automatic run_traffic(input int unsigned budget);
    int unsigned stop_at;
    stop_at = items_sent + budget;
    while (items_sent < stop_at) begin
      if ($urandom_range(99) < 85)
        send_message(($urandom_range(9) == 0) ? $urandom_range(40, 13) : $urandom_range(12, 1));
      else
        push_item(rand64(), 4'($urandom), $urandom_range(3) == 0);
    end
  endtask

  initial begin
    rst_ni            <= 1'b0;
    psel              <= 1'b0;
    penable           <= 1'b0;
    pwrite            <= 1'b0;
    paddr             <= '0;
    pwdata            <= '0;
    in_bus.valid      <= 1'b0;
    in_bus.data_in    <= '0;
    in_bus.byte_count <= '0;
    in_bus.first_item <= 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: all-zero key and nonce from reset
    tx_idle_pct = 28;
    rx_idle_pct = 60;
    settings_used = 1;
    push_item('0, 4'd8, 1'b1);
    for (int i = 1; i < 8; i++) push_item({64{1'b1}}, 4'd8, 1'b0);
    // second block: empty, oversized and short counts mid-block
    push_item({64{1'b1}}, 4'd0, 1'b0);
    push_item({64{1'b1}}, 4'd15, 1'b0);
    push_item({64{1'b1}}, 4'd9, 1'b0);
    push_item({64{1'b1}}, 4'd1, 1'b0);
    push_item({64{1'b1}}, 4'd7, 1'b0);
    // restart in the middle of a block
    push_item(rand64(), 4'd8, 1'b1);
    push_item(rand64(), 4'd3, 1'b0);
    push_item(rand64(), 4'd8, 1'b1);
    push_item('0, 4'd8, 1'b0);

    load_keys({64{1'b1}}, {64{1'b1}}, {64{1'b1}}, {64{1'b1}}, {64{1'b1}});
    push_item('0, 4'd8, 1'b1);
    push_item({64{1'b1}}, 4'd2, 1'b0);
    run_traffic(170);
    load_keys(rand64(), rand64(), rand64(), rand64(), rand64());
    run_traffic(170);

    tx_idle_pct = 60;
    rx_idle_pct = 28;
    load_keys(rand64(), rand64(), rand64(), rand64(), rand64());
    run_traffic(170);
    load_keys({64{1'b1}}, '0, {64{1'b1}}, '0, '0);
    run_traffic(170);

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    load_keys(rand64(), rand64(), rand64(), rand64(), rand64());
    // long receiver hold-off while the sender keeps pushing
    rx_hold = 400;
    send_message(30);
    run_traffic(140);
    load_keys('0, '0, '0, '0, '0);
    run_traffic(170);

    wait_for_outputs();
    repeat (SETTLE_TICKS) @(posedge clk_i);
    $display("Covered %0d input transactions under %0d key/nonce settings, counts 0-15,",
             items_sent, settings_used);
    $display("mid-block restarts and a long output stall; %0d results compared, %0d mismatches.",
             calc.compared, calc.mismatches);
    if (calc.mismatches == 0 && calc.awaited.size() == 0) begin
      $display("tb_chacha20_stream_xor passed");
    end else begin
      $display("tb_chacha20_stream_xor failed");
    end
    $finish;
  end

endmodule
